// ===== rtl/qmsa_pkg.sv =====
package qmsa_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int MIN_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID    = 2'd1;

    // register reset values
    localparam logic [SAMPLE_W-1:0]  ERROR_MARKER_RST = 16'hFFFF;
    localparam logic [MIN_CNT_W-1:0] MIN_VALID_RST    = 5'd8;

    // commands from controller to datapath
    typedef struct packed {
        logic acc;       // take one item into the running sum
        logic div_step;  // one restoring division step
        logic load_out;  // move quotient and flag into the result register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last_sample;  // next item closes the block
    } t_dp_sts;

endpackage

// ===== rtl/qmsa_ctrl.sv =====
module qmsa_ctrl
    import qmsa_pkg::*;
#(
    parameter int SUM_W = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.acc  = in_acc;
                if (in_acc && i_sts.last_sample) begin
                    n_state = S_DIV;
                    n_step  = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/qmsa_dp.sv =====
module qmsa_dp
    import qmsa_pkg::*;
#(
    parameter int SAMPLES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic [SAMPLE_W-1:0]  i_error_marker,
    input  logic [MIN_CNT_W-1:0] i_min_valid,
    output t_dp_sts              o_sts,
    output logic [SAMPLE_W-1:0]  o_mean,
    output logic                 o_ok
);

    localparam int IDX_W = $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
    localparam int CMP_W = (CNT_W > MIN_CNT_W) ? CNT_W : MIN_CNT_W;

    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic                r_ok;
    logic [SAMPLE_W-1:0] r_mean;
    logic                r_ok_out;

    logic                sample_ok;
    logic                last;
    logic [MIN_CNT_W-1:0] need;
    logic                enough;
    logic [CNT_W:0]      rem_sh;
    logic                ge;

    assign sample_ok = (i_sample != i_error_marker);
    assign last      = (r_idx == IDX_W'(SAMPLES - 1));
    assign o_sts.last_sample = last;

    assign n_sum = sample_ok ? (r_sum + SUM_W'(i_sample)) : r_sum;
    assign n_cnt = sample_ok ? (r_cnt + 1'b1) : r_cnt;

    // a minimum of zero behaves as one
    assign need   = (i_min_valid == '0) ? MIN_CNT_W'(1) : i_min_valid;
    assign enough = (CMP_W'(n_cnt) >= CMP_W'(need));

    // restoring division, one quotient bit per step
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_cmd.acc) begin
            if (last) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && last) begin
            r_quo <= n_sum;
            r_rem <= '0;
            r_div <= n_cnt;
            r_ok  <= enough;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_mean   <= r_ok ? r_quo[SAMPLE_W-1:0] : '0;
            r_ok_out <= r_ok;
        end
    end

    assign o_mean = r_mean;
    assign o_ok   = r_ok_out;

endmodule

// ===== rtl/quorum_masked_sample_average.sv =====
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_raw_distance
// result  | out       | o_out_valid / i_out_ready  | o_mean_distance, o_measurement_ok
// config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an item that does not close a block leaves ready high
// the item closing a block starts the bit-serial restoring divider over the SUM_W-bit
// sum (SUM_W = 16 + clog2(SAMPLES), 20 at SAMPLES = 16); ready stays low until the
// result register, once it is free, is loaded with the quotient
// the result register holds while i_out_ready is low; the next block still accumulates
// synchronous active-low reset clears sum, count, index and registers to defaults
module quorum_masked_sample_average
    import qmsa_pkg::*;
#(
    parameter int SAMPLES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_raw_distance,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]   o_mean_distance,
    output logic                  o_measurement_ok,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // running sum must hold SAMPLES full-scale readings
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);

    logic [SAMPLE_W-1:0]  r_error_marker;
    logic [MIN_CNT_W-1:0] r_min_valid;
    t_dp_cmd              cmd;
    t_dp_sts              sts;

    // registers are always writable; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_marker <= ERROR_MARKER_RST;
            r_min_valid    <= MIN_VALID_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ERROR_MARKER: r_error_marker <= i_cfg_data[SAMPLE_W-1:0];
                CFG_MIN_VALID:    r_min_valid    <= i_cfg_data[MIN_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencing: accumulate, divide, hand over the result
    qmsa_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // sum, count, index, divider and result register
    qmsa_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample       (i_raw_distance),
        .i_error_marker (r_error_marker),
        .i_min_valid    (r_min_valid),
        .o_sts          (sts),
        .o_mean         (o_mean_distance),
        .o_ok           (o_measurement_ok)
    );

endmodule

// ===== rtl/qmsa_checker.sv =====
module qmsa_checker
    import qmsa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [SAMPLE_W-1:0]   o_mean_distance,
    input logic                  o_measurement_ok
);

    // a failed block reports a zero mean
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_measurement_ok |-> o_mean_distance == '0)
        else $error("failed block with nonzero mean");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mean_distance)
            && $stable(o_measurement_ok))
        else $error("result dropped or changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a new result appears only after the divider, when input is held off
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without division phase");

endmodule

bind quorum_masked_sample_average qmsa_checker u_qmsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_mean_distance  (o_mean_distance),
    .o_measurement_ok (o_measurement_ok)
);

// ===== tb/tb.sv =====
module tb;
    import qmsa_pkg::*;

    // block geometry and timing budget
    localparam int BLOCK_LEN     = 16;
    localparam int POS_W         = $clog2(BLOCK_LEN);
    localparam int SUM_W         = SAMPLE_W + POS_W;
    localparam int SETTLE_CYCLES = 32;    // covers the divider and the result load, with slack
    localparam int IDLE_LIMIT    = 3000;  // cycles with no handshake at all before giving up
    localparam int PHASES        = 12;

    // register indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {ACT_SAMPLE, ACT_WRITE, ACT_DRAIN} t_act_kind;

    // one pending action for the driver: a sample, a register write, or a wait for quiet
    typedef struct {
        t_act_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;  // sample value or register data
    } t_action;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic                ok;
    } t_block_result;

    // receiver behavior, switched to a randomly chosen mode at random times
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_LONG_STALL, RX_SPARSE} t_rx_mode;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_raw_distance   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [SAMPLE_W-1:0]   o_mean_distance;
    logic                  o_measurement_ok;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    quorum_masked_sample_average #(
        .SAMPLES(BLOCK_LEN)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_raw_distance  (i_raw_distance),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mean_distance (o_mean_distance),
        .o_measurement_ok(o_measurement_ok),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // block averaging predictor: own copy of registers and accumulator
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0]  pred_marker;
    logic [MIN_CNT_W-1:0] pred_min;
    logic [SUM_W-1:0]     acc_sum;
    logic [MIN_CNT_W-1:0] acc_count;
    logic [POS_W-1:0]     acc_pos;

    t_block_result expected_means[$];
    int owed = 0;           // results predicted but not yet taken, updated at the clock edge
    int mismatches = 0;
    int samples_taken = 0;
    int writes_done = 0;
    int blocks_ok = 0;
    int blocks_failed = 0;
    int results_seen = 0;

    // take one sample; returns 1 with the block result when it closes a block
    function automatic logic close_block_mean(input logic [SAMPLE_W-1:0] sample,
                                              output t_block_result res);
        logic [MIN_CNT_W-1:0] need;
        logic [SUM_W-1:0]     quot;
        res = '0;
        if (sample != pred_marker) begin
            acc_sum   = acc_sum + SUM_W'(sample);
            acc_count = acc_count + 1'b1;
        end
        if (int'(acc_pos) + 1 < BLOCK_LEN) begin
            acc_pos = acc_pos + 1'b1;
            return 1'b0;
        end
        // a minimum of zero still needs one valid sample
        need = (pred_min == '0) ? MIN_CNT_W'(1) : pred_min;
        if (acc_count >= need && acc_count != '0) begin
            quot     = acc_sum / SUM_W'(acc_count);
            res.mean = quot[SAMPLE_W-1:0];
            res.ok   = 1'b1;
        end
        acc_sum   = '0;
        acc_count = '0;
        acc_pos   = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: registers, samples and results seen at the clock edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_block_result due;
        t_block_result made_res;
        logic          made;
        logic          took;
        if (!i_rst_n) begin
            pred_marker = ERROR_MARKER_RST;
            pred_min    = MIN_VALID_RST;
            acc_sum     = '0;
            acc_count   = '0;
            acc_pos     = '0;
            owed       <= 0;
        end else begin
            made = 1'b0;
            took = 1'b0;
            // result items first; nothing closed at this edge can be out yet
            if (o_out_valid && i_out_ready) begin
                took = 1'b1;
                results_seen++;
                if (expected_means.size() == 0) begin
                    flag_mismatch($sformatf("result %0d with none pending: mean %0d ok %0b",
                                            results_seen, o_mean_distance, o_measurement_ok));
                end else begin
                    due = expected_means.pop_front();
                    if (o_mean_distance !== due.mean) begin
                        flag_mismatch($sformatf("result %0d mean_distance: expected %0d, got %0d",
                                                results_seen, due.mean, o_mean_distance));
                    end
                    if (o_measurement_ok !== due.ok) begin
                        flag_mismatch($sformatf("result %0d measurement_ok: expected %0b, got %0b",
                                                results_seen, due.ok, o_measurement_ok));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                writes_done++;
                case (i_cfg_index)
                    CFG_ERROR_MARKER: pred_marker = i_cfg_data[SAMPLE_W-1:0];
                    CFG_MIN_VALID:    pred_min    = i_cfg_data[MIN_CNT_W-1:0];
                    default: ;  // spare indexes change nothing
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                samples_taken++;
                made = close_block_mean(i_raw_distance, made_res);
                if (made) begin
                    expected_means.push_back(made_res);
                    if (made_res.ok) begin
                        blocks_ok++;
                    end else begin
                        blocks_failed++;
                    end
                end
            end
            owed <= owed + int'(made) - int'(took);
        end
    end

    // ------------------------------------------------------------------
    // driver: bursts of items from the pending queue, waits for quiet
    // before each group of register writes
    // ------------------------------------------------------------------
    t_action stim_q[$];
    int      gap_left = 0;
    int      burst_left = 0;
    logic    draining = 1'b0;
    int      drain_quiet = 0;

    always @(posedge i_clk) begin
        t_action act;
        logic    next_in_valid;
        logic    next_cfg_valid;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if ((i_in_valid && !o_in_ready) || (i_cfg_valid && !o_cfg_ready)) begin
            // offered item not taken yet: hold valid and payload
        end else begin
            next_in_valid  = 1'b0;
            next_cfg_valid = 1'b0;
            if (draining) begin
                // every result in, then a quiet stretch for a divide still running
                if (owed == 0) begin
                    drain_quiet++;
                end else begin
                    drain_quiet = 0;
                end
                if (drain_quiet >= SETTLE_CYCLES) begin
                    draining = 1'b0;
                end
            end else if (gap_left != 0) begin
                gap_left--;
            end else if (stim_q.size() != 0) begin
                act = stim_q.pop_front();
                case (act.kind)
                    ACT_SAMPLE: begin
                        next_in_valid = 1'b1;
                        i_raw_distance <= act.data;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            // new burst; a third of them follow with no gap at all
                            burst_left = $urandom_range(1, 48);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end
                    ACT_WRITE: begin
                        next_cfg_valid = 1'b1;
                        i_cfg_index <= act.idx;
                        i_cfg_data  <= act.data;
                    end
                    default: begin
                        draining    = 1'b1;
                        drain_quiet = 0;
                    end
                endcase
            end
            i_in_valid  <= next_in_valid;
            i_cfg_valid <= next_cfg_valid;
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready pattern changes to a randomly chosen mode at random times
    // ------------------------------------------------------------------
    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_left = 0;
    int       rx_stall = 0;

    always @(posedge i_clk) begin
        logic next_ready;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 300);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_ALWAYS: next_ready = 1'b1;
                RX_COIN:   next_ready = 1'($urandom_range(0, 1));
                RX_LONG_STALL: begin
                    if (rx_stall != 0) begin
                        rx_stall--;
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                        if ($urandom_range(0, 3) == 0) begin
                            rx_stall = $urandom_range(1, 40);
                        end
                    end
                end
                default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
            i_out_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no handshake on any channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                     || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles", IDLE_LIMIT);
            $display("quorum_masked_sample_average: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    int                  gen_pos = 0;
    int                  blk_bad_pct = 0;
    int                  blk_style = 0;
    logic [SAMPLE_W-1:0] blk_base = '0;

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value);
        t_action a;
        a.kind = ACT_SAMPLE;
        a.idx  = '0;
        a.data = value;
        stim_q.push_back(a);
    endtask

    // register writes go out only once the block has gone quiet
    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_action a;
        a.idx  = idx;
        a.data = data;
        if (stim_q.size() == 0 || stim_q[$].kind == ACT_SAMPLE) begin
            a.kind = ACT_DRAIN;
            stim_q.push_back(a);
        end
        a.kind = ACT_WRITE;
        stim_q.push_back(a);
    endtask

    // per block: a share of marker samples, and a style for the valid ones
    function automatic logic [SAMPLE_W-1:0] next_random_sample(input logic [SAMPLE_W-1:0] marker);
        logic [SAMPLE_W-1:0] v;
        if (gen_pos == 0) begin
            blk_bad_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 100);
            blk_base    = 16'($urandom);
            blk_style   = $urandom_range(0, 3);
        end
        gen_pos = (gen_pos + 1) % BLOCK_LEN;
        if ($urandom_range(1, 100) <= blk_bad_pct) begin
            return marker;
        end
        case (blk_style)
            0: v = 16'($urandom);
            1: v = blk_base + 16'($urandom_range(0, 63));   // clustered readings
            2: v = 16'hFFFF;                                 // largest possible sum
            default: begin
                case ($urandom_range(0, 2))
                    0:       v = 16'h0000;
                    1:       v = 16'hFFFF;
                    default: v = 16'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [SAMPLE_W-1:0]  marker;
        logic [MIN_CNT_W-1:0] need;
        int                   n;

        // spare register indexes must be ignored
        queue_write(CFG_SPARE_A, 16'($urandom));
        queue_write(CFG_SPARE_B, 16'($urandom));
        // zero minimum written with junk in the upper data bits, zero as the marker
        queue_write(CFG_ERROR_MARKER, 16'h0000);
        queue_write(CFG_MIN_VALID, 16'hFFE0);
        repeat (8) queue_sample(16'h0000);
        // marker moved half way through the block: all-ones now dropped, zero now valid,
        // so one valid sample has to pass the zero minimum
        queue_write(CFG_ERROR_MARKER, 16'hFFFF);
        repeat (7) queue_sample(16'hFFFF);
        queue_sample(16'h0000);

        // random phases; lengths need not be whole blocks, so settings change mid-block too
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin marker = ERROR_MARKER_RST; need = MIN_VALID_RST; end
                1:       begin marker = 16'h0000;         need = 5'd1;  end
                2:       begin marker = 16'($urandom);    need = 5'd16; end
                3:       begin marker = 16'($urandom);    need = 5'd17; end  // never met
                4:       begin marker = 16'hFFFF;         need = 5'd0;  end
                5:       begin marker = 16'($urandom);    need = 5'd31; end
                6:       begin marker = 16'h0000;         need = 5'd16; end
                7:       begin marker = 16'($urandom);    need = 5'd2;  end
                default: begin marker = 16'($urandom);    need = 5'($urandom); end
            endcase
            queue_write(CFG_ERROR_MARKER, marker);
            queue_write(CFG_MIN_VALID, (16'($urandom) & 16'hFFE0) | 16'(need));
            n = $urandom_range(110, 160);
            repeat (n) queue_sample(next_random_sample(marker));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything handed over, then every result in, then a quiet tail
        do @(negedge i_clk);
        while (stim_q.size() != 0 || i_in_valid || i_cfg_valid || draining);
        while (owed != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d samples in %0d blocks: %0d averaged, %0d rejected for too few valid readings",
                 samples_taken, blocks_ok + blocks_failed, blocks_ok, blocks_failed);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 writes_done, PHASES + 2, mismatches);
        if (mismatches == 0) begin
            $display("quorum_masked_sample_average: match");
        end else begin
            $display("quorum_masked_sample_average: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qmsa_pkg.sv
rtl/qmsa_ctrl.sv
rtl/qmsa_dp.sv
rtl/quorum_masked_sample_average.sv
rtl/qmsa_checker.sv
tb/tb.sv
